// ===== design/sfrx_pkg.sv =====
// shared types, constants and helpers for the stuffed frame receiver
package sfrx_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TableW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned OutDataW = 104;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_BYTE    = 2'd0,
    CFG_ADDRESS_TABLE = 2'd1,
    CFG_COMMAND_TABLE = 2'd2,
    CFG_LEN_MASK      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_START    = 3'd0,
    ST_ADDRESS  = 3'd1,
    ST_COMMAND  = 3'd2,
    ST_DATA     = 3'd3,
    ST_CHECKSUM = 3'd4
  } parse_state_e;

  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_BAD      = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0]  frame_byte;
    logic [TableW-1:0] address_table;
    logic [TableW-1:0] command_table;
    logic [ByteW-1:0]  len_mask;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0]    rx_checksum;
    logic [PayloadW-1:0] pkt_payload;
    logic [ByteW-1:0]    pkt_length;
    logic [ByteW-1:0]    pkt_command;
    logic [ByteW-1:0]    pkt_address;
    status_e             status;
  } result_t;

  // true when b equals any of the four bytes of the table
  function automatic logic in_table(logic [TableW-1:0] tbl, logic [ByteW-1:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (tbl[8*i +: 8] == b) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ===== design/sfrx_cfg_regs.sv =====
// configuration register bank of the stuffed frame receiver
module sfrx_cfg_regs
  import sfrx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_byte    <= '0;
      cfg_q.address_table <= '0;
      cfg_q.command_table <= '0;
      cfg_q.len_mask      <= 8'd15;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_BYTE:    cfg_q.frame_byte    <= cfg_data_i[ByteW-1:0];
        CFG_ADDRESS_TABLE: cfg_q.address_table <= cfg_data_i[TableW-1:0];
        CFG_COMMAND_TABLE: cfg_q.command_table <= cfg_data_i[TableW-1:0];
        CFG_LEN_MASK:      cfg_q.len_mask      <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/sfrx_parser.sv =====
// frame parser: state machine, de-stuffing, checksum and payload store
module sfrx_parser
  import sfrx_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             fire_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             emit_o,
  output result_t          result_o
);

  localparam logic [ByteW-1:0] StoreCap = ByteW'(MAX_PAYLOAD);

  parse_state_e     state_q, state_d;
  logic [ByteW-1:0] address_q, address_d;
  logic [ByteW-1:0] command_q, command_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] index_q, index_d;
  logic             armed_q, armed_d;
  logic             ovf_q, ovf_d;
  logic             store_we;
  logic [ByteW-1:0] store_q [MAX_PAYLOAD];
  logic [PayloadW-1:0] payload;
  logic             is_frame;

  assign is_frame = (byte_i == cfg_i.frame_byte);

  always_comb begin
    state_d   = state_q;
    address_d = address_q;
    command_d = command_q;
    xor_d     = xor_q;
    len_d     = len_q;
    index_d   = index_q;
    armed_d   = armed_q;
    ovf_d     = ovf_q;
    store_we  = 1'b0;
    emit_o    = 1'b0;
    unique case (state_q)
      ST_ADDRESS: begin
        if (in_table(cfg_i.address_table, byte_i)) begin
          address_d = byte_i;
          state_d   = ST_COMMAND;
        end else begin
          state_d = is_frame ? ST_ADDRESS : ST_START;
        end
      end
      ST_COMMAND: begin
        if (in_table(cfg_i.command_table, byte_i)) begin
          command_d = byte_i;
          xor_d     = byte_i;
          len_d     = byte_i & cfg_i.len_mask;
          index_d   = '0;
          ovf_d     = 1'b0;
          armed_d   = 1'b1;
          state_d   = ((byte_i & cfg_i.len_mask) == '0) ? ST_CHECKSUM : ST_DATA;
        end else begin
          state_d = is_frame ? ST_ADDRESS : ST_START;
        end
      end
      ST_DATA, ST_CHECKSUM: begin
        if (armed_q && is_frame) begin
          armed_d = 1'b0;
        end else if (!armed_q && !is_frame) begin
          // lone frame byte: this byte restarts the frame as its address
          address_d = byte_i;
          state_d   = ST_COMMAND;
        end else begin
          armed_d = 1'b1;
          if (state_q == ST_DATA) begin
            if (index_q < StoreCap) store_we = 1'b1;
            else                    ovf_d    = 1'b1;
            index_d = index_q + 8'd1;
            xor_d   = xor_q ^ byte_i;
            if (index_q + 8'd1 >= len_q) state_d = ST_CHECKSUM;
          end else begin
            emit_o  = 1'b1;
            state_d = ST_START;
          end
        end
      end
      default: state_d = is_frame ? ST_ADDRESS : ST_START;
    endcase
  end

  // only bytes written in this frame are shown
  always_comb begin
    payload = '0;
    for (int i = 0; i < int'(MAX_PAYLOAD); i++) begin
      if (ByteW'(i) < index_q) payload[8*i +: 8] = store_q[i];
    end
  end

  always_comb begin
    result_o.rx_checksum = byte_i;
    result_o.pkt_payload = payload;
    result_o.pkt_length  = len_q;
    result_o.pkt_command = command_q;
    result_o.pkt_address = address_q;
    if (ovf_q)                 result_o.status = STATUS_OVERFLOW;
    else if (xor_q == byte_i)  result_o.status = STATUS_GOOD;
    else                       result_o.status = STATUS_BAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_START;
      address_q <= '0;
      command_q <= '0;
      xor_q     <= '0;
      len_q     <= '0;
      index_q   <= '0;
      armed_q   <= 1'b1;
      ovf_q     <= 1'b0;
    end else if (fire_i) begin
      state_q   <= state_d;
      address_q <= address_d;
      command_q <= command_d;
      xor_q     <= xor_d;
      len_q     <= len_d;
      index_q   <= index_d;
      armed_q   <= armed_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(MAX_PAYLOAD); i++) begin
      if (fire_i && store_we && index_q == ByteW'(i)) store_q[i] <= byte_i;
    end
  end

endmodule

// ===== design/sfrx_out_reg.sv =====
// result register holding one finished packet for the output side
module sfrx_out_reg
  import sfrx_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    take_i,
  output logic    valid_o,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) result_q <= result_i;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== design/stuffed_frame_receiver_xor.sv =====
// top level of the byte stuffed frame receiver with xor checksum
//
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  one raw line byte per request
//  m_axis    out        m_axis_tvalid / m_axis_tready  one finished packet per request
//  cfg       in         cfg_we_i                       register index and write data
//
//  every byte is taken in one cycle; a byte may be taken on every clock
//  the parser updates its state on the byte and, at a checksum byte, loads
//  the result register in the same edge, so a packet shows one cycle later
//  s_axis_tready is low only while a packet waits and m_axis_tready is low
//  reset clears the parser to hunting for the frame byte and empties the output
module stuffed_frame_receiver_xor
  import sfrx_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side, tdata: rx_byte[7:0]
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,
  // master side, tdata: status[1:0], pkt_address[9:2], pkt_command[17:10],
  // pkt_length[25:18], pkt_payload[89:26], rx_checksum[97:90], zeros[103:98]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  logic    in_fire;
  logic    emit;
  result_t result;
  result_t out_result;

  // the output register frees up when its packet is taken this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  sfrx_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfrx_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (in_fire),
    .byte_i   (s_axis_tdata),
    .emit_o   (emit),
    .result_o (result)
  );

  sfrx_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_fire && emit),
    .result_i (result),
    .take_i   (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .result_o (out_result)
  );

  // packed result is 98 bits, padded with zeros to whole bytes
  assign m_axis_tdata = {6'b0, out_result};

endmodule

// ===== design/sfrx_checker.sv =====
// port level checks of the stuffed frame receiver, bound to the top level
module sfrx_checker
  import sfrx_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // a packet waiting on the output stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  // input side is back-pressured only by a waiting packet
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow the output register");

  // a packet appears only after a byte was taken
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("packet without an input byte");

  // status code three is never sent
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("unused status code");

  // a nonzero last payload byte needs a length of at least eight
  a_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[89:82] != 8'd0 |-> m_axis_tdata[25:18] >= 8'd8)
    else $error("payload byte beyond the frame length");

endmodule

bind stuffed_frame_receiver_xor sfrx_checker u_sfrx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/stuffed_frame_receiver_xor_tb.sv =====
// self-checking testbench: random framed byte streams in, predicted packets checked on the output
module stuffed_frame_receiver_xor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfrx_pkg::*;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned MaxPayload    = 8;
  localparam int unsigned StoreSlots    = (MaxPayload > 8) ? 8 : MaxPayload;
  localparam int unsigned ByteTarget    = 1900;
  // the packet shows in the cycle after its checksum byte, so this settle time covers any work left
  localparam int unsigned SettleCycles  = 4;
  // limit on the whole run
  localparam int unsigned TimeoutCycles = 1_000_000;
  localparam int unsigned ResBits       = $bits(result_t);

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_RESTART,
    LINE_NOISE
  } frame_kind_e;

  // mirrors the parser and holds the packets still due on the master side
  class packet_scoreboard;
    logic [ByteW-1:0]  frame_byte;
    logic [TableW-1:0] address_table;
    logic [TableW-1:0] command_table;
    logic [ByteW-1:0]  len_mask;
    parse_state_e      state;
    logic [ByteW-1:0]  cur_address;
    logic [ByteW-1:0]  cur_command;
    logic [ByteW-1:0]  running_xor;
    logic [ByteW-1:0]  expected_len;
    logic [ByteW-1:0]  byte_index;
    logic              escape_armed;
    logic              overflowed;
    logic [ByteW-1:0]  store [StoreSlots];
    result_t           packets_due [$];
    int unsigned       mismatches;

    function new();
      frame_byte    = '0;
      address_table = '0;
      command_table = '0;
      len_mask      = 8'h0f;
      state         = ST_START;
      cur_address   = '0;
      cur_command   = '0;
      running_xor   = '0;
      expected_len  = '0;
      byte_index    = '0;
      escape_armed  = 1'b1;
      overflowed    = 1'b0;
      foreach (store[i]) store[i] = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_FRAME_BYTE:    frame_byte    = value[ByteW-1:0];
        CFG_ADDRESS_TABLE: address_table = value[TableW-1:0];
        CFG_COMMAND_TABLE: command_table = value[TableW-1:0];
        CFG_LEN_MASK:      len_mask      = value[ByteW-1:0];
        default: ;
      endcase
    endfunction

    function bit table_hit(logic [TableW-1:0] tbl, logic [ByteW-1:0] b);
      for (int i = 0; i < 4; i++) begin
        if (tbl[8*i +: 8] == b) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void rx_byte_taken(logic [ByteW-1:0] b);
      logic    is_frame;
      result_t pkt;
      int      n;
      is_frame = (b == frame_byte);
      case (state)
        ST_ADDRESS, ST_COMMAND: begin
          if (state == ST_ADDRESS && table_hit(address_table, b)) begin
            cur_address = b;
            state       = ST_COMMAND;
          end else if (state == ST_COMMAND && table_hit(command_table, b)) begin
            cur_command  = b;
            running_xor  = b;
            expected_len = b & len_mask;
            byte_index   = '0;
            overflowed   = 1'b0;
            escape_armed = 1'b1;
            state        = (expected_len == 0) ? ST_CHECKSUM : ST_DATA;
          end else begin
            state = is_frame ? ST_ADDRESS : ST_START;
          end
        end
        ST_DATA, ST_CHECKSUM: begin
          if (escape_armed && is_frame) begin
            escape_armed = 1'b0;
          end else if (!escape_armed && !is_frame) begin
            cur_address = b;
            state       = ST_COMMAND;
          end else begin
            escape_armed = 1'b1;
            if (state == ST_DATA) begin
              if (byte_index < StoreSlots) store[byte_index] = b;
              else overflowed = 1'b1;
              byte_index++;
              running_xor ^= b;
              if (byte_index >= expected_len) state = ST_CHECKSUM;
            end else begin
              pkt = '0;
              n   = (byte_index < StoreSlots) ? int'(byte_index) : StoreSlots;
              for (int i = 0; i < n; i++) pkt.pkt_payload[8*i +: 8] = store[i];
              pkt.status      = overflowed ? STATUS_OVERFLOW
                              : ((running_xor == b) ? STATUS_GOOD : STATUS_BAD);
              pkt.pkt_address = cur_address;
              pkt.pkt_command = cur_command;
              pkt.pkt_length  = expected_len;
              pkt.rx_checksum = b;
              packets_due.push_back(pkt);
              state = ST_START;
            end
          end
        end
        default: state = is_frame ? ST_ADDRESS : ST_START;
      endcase
    endfunction

    function string show(result_t r);
      return $sformatf("st=%0d adr=%h cmd=%h len=%h pay=%h sum=%h", r.status,
                       r.pkt_address, r.pkt_command, r.pkt_length, r.pkt_payload,
                       r.rx_checksum);
    endfunction

    function void flag(string msg);
      if (mismatches < 10) $display("mismatch: %s", msg);
      mismatches++;
    endfunction

    function void packet_seen(logic [OutDataW-1:0] data);
      result_t got;
      result_t want;
      string   bad;
      got = result_t'(data[ResBits-1:0]);
      if (packets_due.size() == 0) begin
        flag($sformatf("packet with none due: %s", show(got)));
        return;
      end
      want = packets_due.pop_front();
      bad  = "";
      if (got.status      !== want.status)      bad = {bad, " status"};
      if (got.pkt_address !== want.pkt_address) bad = {bad, " pkt_address"};
      if (got.pkt_command !== want.pkt_command) bad = {bad, " pkt_command"};
      if (got.pkt_length  !== want.pkt_length)  bad = {bad, " pkt_length"};
      if (got.pkt_payload !== want.pkt_payload) bad = {bad, " pkt_payload"};
      if (got.rx_checksum !== want.rx_checksum) bad = {bad, " rx_checksum"};
      if (data[OutDataW-1:ResBits] !== '0)      bad = {bad, " padding"};
      if (bad != "") begin
        flag($sformatf("field%s: expected %s, actual %s", bad, show(want), show(got)));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  packet_scoreboard sb;
  int unsigned      sent_bytes = 0;
  bit               tx_burst   = 1'b0;   // sender runs without gaps
  bit               rx_burst   = 1'b0;   // receiver runs without stalls
  int               stall_left = 0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  stuffed_frame_receiver_xor #(
    .MAX_PAYLOAD (MaxPayload)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // gap length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // payload bytes lean towards the frame byte and the extremes to exercise stuffing
  function automatic logic [ByteW-1:0] payload_byte();
    int r;
    r = $urandom_range(0, 11);
    if (r < 2) return sb.frame_byte;
    if (r == 2) return 8'h00;
    if (r == 3) return 8'hff;
    return ByteW'($urandom);
  endfunction

  // monitor: sampled at the edge, before any nba of this step lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.packet_seen(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.rx_byte_taken(s_axis_tdata);
      if (cfg_we_i) sb.write_reg(cfg_idx_e'(cfg_idx_i), cfg_data_i);
    end
  end

  // receiver: random stalls, with stretches of none
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) rx_burst = ~rx_burst;
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_burst && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // one request on the slave side, then an optional gap with tvalid low
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_bytes++;
    gap = tx_burst ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // payload and checksum bytes: a literal frame byte goes out doubled
  task automatic send_stuffed(input logic [ByteW-1:0] b);
    send_byte(b);
    if (b == sb.frame_byte) send_byte(b);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop requesting and let every due packet drain before touching registers;
  // the monitor first sees the last byte taken, then the due queue is checked
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.packets_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one setting per phase; the first ones take the extremes
  task automatic configure(input int k);
    logic [ByteW-1:0]  fb;
    logic [ByteW-1:0]  mask;
    logic [TableW-1:0] adr_tbl;
    logic [TableW-1:0] cmd_tbl;
    fb      = (k == 0) ? 8'h00 : (k == 1) ? 8'hff : ByteW'($urandom);
    adr_tbl = (k == 0) ? 32'h0000_0000 : (k == 1) ? 32'hffff_ffff : $urandom;
    cmd_tbl = (k == 0) ? 32'hffff_ffff : (k == 1) ? 32'h0000_0000 : $urandom;
    // frame byte doubling as an address or command now and then
    if ($urandom_range(0, 2) == 0) adr_tbl[8*$urandom_range(0, 3) +: 8] = fb;
    if ($urandom_range(0, 2) == 0) cmd_tbl[8*$urandom_range(0, 3) +: 8] = fb;
    case (k % 6)
      0:       mask = 8'h00;
      1:       mask = 8'h0f;
      2:       mask = 8'hff;
      3:       mask = 8'h07;
      4:       mask = 8'h0b;
      default: mask = ByteW'($urandom);
    endcase
    write_cfg(CFG_FRAME_BYTE, CfgDataW'(fb));
    write_cfg(CFG_ADDRESS_TABLE, adr_tbl);
    write_cfg(CFG_COMMAND_TABLE, cmd_tbl);
    write_cfg(CFG_LEN_MASK, CfgDataW'(mask));
  endtask

  // a framed packet with random content; the restart kind breaks off part way
  task automatic send_frame(input frame_kind_e kind);
    logic [ByteW-1:0] adr;
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] d;
    int               cut;
    adr = sb.address_table[8*$urandom_range(0, 3) +: 8];
    cmd = sb.command_table[8*$urandom_range(0, 3) +: 8];
    send_byte(sb.frame_byte);
    send_byte(adr);
    if (kind == FRAME_RESTART) begin
      len = cmd & sb.len_mask;
      cut = $urandom_range(0, len);
      send_byte(cmd);
      for (int i = 0; i < cut; i++) send_stuffed(payload_byte());
      // lone frame byte then any other byte: new address, table not consulted
      send_byte(sb.frame_byte);
      adr = ByteW'($urandom);
      if (adr == sb.frame_byte) adr = adr ^ 8'h01;
      send_byte(adr);
      cmd = sb.command_table[8*$urandom_range(0, 3) +: 8];
    end
    len = cmd & sb.len_mask;
    sum = cmd;
    send_byte(cmd);
    for (int i = 0; i < len; i++) begin
      d = payload_byte();
      sum ^= d;
      send_stuffed(d);
    end
    if (kind == FRAME_BAD_SUM) sum = ByteW'($urandom);
    send_stuffed(sum);
  endtask

  // unframed junk with frame bytes sprinkled in
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_byte(sb.frame_byte);
      else send_byte(ByteW'($urandom));
    end
  endtask

  initial begin
    logic [ByteW-1:0] reset_seq [$];
    logic [ByteW-1:0] known_seq [$];
    int unsigned      phase_end;
    int               r;
    sb            = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_FRAME_BYTE;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: frame byte zero and every table entry zero, address match wins
    reset_seq = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    foreach (reset_seq[i]) send_byte(reset_seq[i]);
    wait_idle();

    write_cfg(CFG_FRAME_BYTE, 32'h0000_007e);
    write_cfg(CFG_ADDRESS_TABLE, 32'hff22_117e);
    write_cfg(CFG_COMMAND_TABLE, 32'h0310_7e09);
    write_cfg(CFG_LEN_MASK, 32'h0000_000f);
    known_seq = '{
      // zero length, checksum right after the command
      8'h7e, 8'h11, 8'h10, 8'h10,
      // frame byte as address, stuffed payload byte
      8'h7e, 8'h7e, 8'h03, 8'h7e, 8'h7e, 8'h00, 8'hff, 8'h82,
      // restart inside the payload, unlisted address taken, bad checksum
      8'h7e, 8'h22, 8'h09, 8'h01, 8'h7e, 8'h55, 8'h10, 8'h00,
      // unknown command drops back to hunting
      8'h7e, 8'h11, 8'h44
    };
    foreach (known_seq[i]) send_byte(known_seq[i]);

    // random phases, each under its own register setting
    for (int k = 0; sent_bytes < ByteTarget; k++) begin
      wait_idle();
      configure(k);
      phase_end = sent_bytes + 150 + $urandom_range(0, 60);
      if (phase_end > ByteTarget) phase_end = ByteTarget;
      while (sent_bytes < phase_end) begin
        tx_burst = ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 9);
        if (r < 7) send_frame(FRAME_GOOD);
        else if (r == 7) send_frame(FRAME_BAD_SUM);
        else if (r == 8) send_frame(FRAME_RESTART);
        else send_noise();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
design/sfrx_pkg.sv
design/sfrx_cfg_regs.sv
design/sfrx_parser.sv
design/sfrx_out_reg.sv
design/stuffed_frame_receiver_xor.sv
design/sfrx_checker.sv
test/stuffed_frame_receiver_xor_tb.sv
